[rtl/utf8v_pkg.sv]
// Shared widths, byte-class limits and second-byte rule codes of the UTF-8 validator.
package utf8v_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 12;
	localparam int unsigned LEFT_W  = 2;
	localparam int unsigned RULE_W  = 3;

	// Reset value of the code point limit.
	localparam logic [COUNT_W-1:0] MAX_POINTS_RST = 12'd160;

	// Byte classes.
	localparam logic [BYTE_W-1:0] ASCII_MIN  = 8'h20;
	localparam logic [BYTE_W-1:0] ASCII_DEL  = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_SURR = 8'hED;
	localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF4;
	localparam logic [BYTE_W-1:0] CONT_MIN   = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_MAX   = 8'hBF;
	localparam logic [BYTE_W-1:0] CONT_A0    = 8'hA0;
	localparam logic [BYTE_W-1:0] CONT_9F    = 8'h9F;
	localparam logic [BYTE_W-1:0] CONT_90    = 8'h90;
	localparam logic [BYTE_W-1:0] CONT_8F    = 8'h8F;

	// Restriction on the first continuation byte after a lead byte.
	localparam logic [RULE_W-1:0] RULE_NONE   = 3'd0;
	localparam logic [RULE_W-1:0] RULE_MIN_A0 = 3'd1;
	localparam logic [RULE_W-1:0] RULE_MAX_9F = 3'd2;
	localparam logic [RULE_W-1:0] RULE_MIN_90 = 3'd3;
	localparam logic [RULE_W-1:0] RULE_MAX_8F = 3'd4;

endpackage

[rtl/utf8v_in_if.sv]
// Valid/ready channel that carries at most one message byte per beat.
interface utf8v_in_if;
	logic                           valid;
	logic                           ready;
	logic [utf8v_pkg::BYTE_W-1:0]   msg_byte;
	logic                           has_byte;
	logic                           last_byte;

	modport source (output valid, output msg_byte, output has_byte, output last_byte,
		input ready);
	modport sink (input valid, input msg_byte, input has_byte, input last_byte,
		output ready);
endinterface

[rtl/utf8v_out_if.sv]
// Valid/ready channel that carries one message verdict per beat.
interface utf8v_out_if;
	logic                           valid;
	logic                           ready;
	logic                           message_ok;
	logic [utf8v_pkg::COUNT_W-1:0]  code_point_total;

	modport source (output valid, output message_ok, output code_point_total,
		input ready);
	modport sink (input valid, input message_ok, input code_point_total,
		output ready);
endinterface

[rtl/utf8_message_validator.sv]
// Strict UTF-8 message validator with a code point limit and one verdict per message.
//
// Usage:
//   msg_in carries one beat per byte: msg_byte, has_byte (0 for an end marker
//   without a byte) and last_byte (ends the message). A beat with has_byte and
//   last_byte both low is an idle beat and changes nothing.
//   verdict carries one beat per message, message_ok and code_point_total,
//   produced for the beat that has last_byte set.
//   cfg_wr_en/cfg_wr_data write the code point limit; write it only between
//   messages. It resets to 160.
// Timing:
//   A byte beat is captured in an input register and decoded in the following
//   cycle by a small decoder and a 12-bit counter compare; the verdict is written
//   into the output register when the last beat advances out of the input register.
//   One beat is accepted every cycle unless a final byte is held in the input register.
// Reset and stalls:
//   arst_n clears the message state, the pipeline valids and sets the limit to
//   160. While verdict.ready is low a waiting verdict holds; non-final bytes keep
//   flowing, and a second final byte waits in the input register, after which
//   msg_in.ready drops.
module utf8_message_validator (
	input  logic                           clk,
	input  logic                           arst_n,
	utf8v_in_if.sink                       msg_in,
	utf8v_out_if.source                    verdict,
	input  logic                           cfg_wr_en,
	input  logic [utf8v_pkg::COUNT_W-1:0]  cfg_wr_data
);

	logic [utf8v_pkg::COUNT_W-1:0] max_points_q;

	logic                          valid_s1;
	logic [utf8v_pkg::BYTE_W-1:0]  byte_s1;
	logic                          has_s1;
	logic                          last_s1;

	logic [utf8v_pkg::LEFT_W-1:0]  bytes_left_q;
	logic [utf8v_pkg::RULE_W-1:0]  rule_q;
	logic [utf8v_pkg::COUNT_W-1:0] count_q;
	logic                          failed_q;
	logic                          seen_q;

	logic [utf8v_pkg::LEFT_W-1:0]  bytes_left_d;
	logic [utf8v_pkg::RULE_W-1:0]  rule_d;
	logic [utf8v_pkg::COUNT_W-1:0] count_d;
	logic                          failed_d;
	logic                          seen_d;
	logic                          finish;
	logic                          cont_bad;

	logic                          out_valid_q;
	logic                          ok_q;
	logic [utf8v_pkg::COUNT_W-1:0] total_q;

	logic                          advance;
	logic                          out_free;

	// The output register can take a verdict when empty or being drained.
	assign out_free = !out_valid_q || verdict.ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign msg_in.ready = !valid_s1 || advance;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_points_q <= utf8v_pkg::MAX_POINTS_RST;
		end else if (cfg_wr_en) begin
			max_points_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_in.ready) begin
			valid_s1 <= msg_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_in.ready && msg_in.valid) begin
			byte_s1 <= msg_in.msg_byte;
			has_s1  <= msg_in.has_byte;
			last_s1 <= msg_in.last_byte;
		end
	end

	// Continuation byte check, including the second-byte rule of the lead.
	always_comb begin
		cont_bad = (byte_s1 < utf8v_pkg::CONT_MIN) || (byte_s1 > utf8v_pkg::CONT_MAX);
		case (rule_q)
			utf8v_pkg::RULE_MIN_A0: cont_bad = cont_bad || (byte_s1 < utf8v_pkg::CONT_A0);
			utf8v_pkg::RULE_MAX_9F: cont_bad = cont_bad || (byte_s1 > utf8v_pkg::CONT_9F);
			utf8v_pkg::RULE_MIN_90: cont_bad = cont_bad || (byte_s1 < utf8v_pkg::CONT_90);
			utf8v_pkg::RULE_MAX_8F: cont_bad = cont_bad || (byte_s1 > utf8v_pkg::CONT_8F);
			default: ;
		endcase
	end

	// Next message state for the byte in the input register.
	always_comb begin
		bytes_left_d = bytes_left_q;
		rule_d       = rule_q;
		count_d      = count_q;
		failed_d     = failed_q;
		seen_d       = seen_q;
		finish       = 1'b0;
		if (has_s1) begin
			seen_d = 1'b1;
			if (!failed_q) begin
				if (bytes_left_q == '0) begin
					if (byte_s1 <= utf8v_pkg::ASCII_DEL) begin
						if (byte_s1 < utf8v_pkg::ASCII_MIN || byte_s1 == utf8v_pkg::ASCII_DEL) begin
							failed_d = 1'b1;
						end else begin
							finish = 1'b1;
						end
					end else if (byte_s1 inside {[utf8v_pkg::LEAD2_MIN:utf8v_pkg::LEAD2_MAX]}) begin
						bytes_left_d = 2'd1;
						rule_d       = utf8v_pkg::RULE_NONE;
					end else if (byte_s1 inside {[utf8v_pkg::LEAD3_MIN:utf8v_pkg::LEAD3_MAX]}) begin
						bytes_left_d = 2'd2;
						if (byte_s1 == utf8v_pkg::LEAD3_MIN) begin
							rule_d = utf8v_pkg::RULE_MIN_A0;
						end else if (byte_s1 == utf8v_pkg::LEAD3_SURR) begin
							rule_d = utf8v_pkg::RULE_MAX_9F;
						end else begin
							rule_d = utf8v_pkg::RULE_NONE;
						end
					end else if (byte_s1 inside {[utf8v_pkg::LEAD4_MIN:utf8v_pkg::LEAD4_MAX]}) begin
						bytes_left_d = 2'd3;
						if (byte_s1 == utf8v_pkg::LEAD4_MIN) begin
							rule_d = utf8v_pkg::RULE_MIN_90;
						end else if (byte_s1 == utf8v_pkg::LEAD4_MAX) begin
							rule_d = utf8v_pkg::RULE_MAX_8F;
						end else begin
							rule_d = utf8v_pkg::RULE_NONE;
						end
					end else begin
						failed_d = 1'b1;
					end
				end else if (cont_bad) begin
					failed_d = 1'b1;
				end else begin
					rule_d       = utf8v_pkg::RULE_NONE;
					bytes_left_d = bytes_left_q - 2'd1;
					finish       = (bytes_left_q == 2'd1);
				end
			end
		end
		// A completed code point either counts or trips the limit.
		if (finish) begin
			if (({1'b0, count_q} + 13'd1) > {1'b0, max_points_q}) begin
				failed_d = 1'b1;
			end else if (count_q != '1) begin
				count_d = count_q + 12'd1;
			end
		end
	end

	// Message state; cleared after each verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			rule_q       <= utf8v_pkg::RULE_NONE;
			count_q      <= '0;
			failed_q     <= 1'b0;
			seen_q       <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				bytes_left_q <= '0;
				rule_q       <= utf8v_pkg::RULE_NONE;
				count_q      <= '0;
				failed_q     <= 1'b0;
				seen_q       <= 1'b0;
			end else begin
				bytes_left_q <= bytes_left_d;
				rule_q       <= rule_d;
				count_q      <= count_d;
				failed_q     <= failed_d;
				seen_q       <= seen_d;
			end
		end
	end

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			ok_q    <= !failed_d && seen_d && (bytes_left_d == '0);
			total_q <= count_d;
		end
	end

	assign verdict.valid            = out_valid_q;
	assign verdict.message_ok       = ok_q;
	assign verdict.code_point_total = total_q;

	// A second-byte rule is only pending inside a three- or four-byte sequence.
	a_rule_in_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		rule_q != utf8v_pkg::RULE_NONE |-> bytes_left_q >= 2'd2)
		else $error("second-byte rule pending outside a multi-byte sequence");

	// A passing verdict always reports at least one code point.
	a_ok_has_points: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> total_q != '0)
		else $error("valid message with zero code points");

	// The message state is cleared once a verdict is taken in.
	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> count_q == '0 && !seen_q && !failed_q && bytes_left_q == '0)
		else $error("message state not cleared after verdict");

	// A verdict waiting on a stalled receiver is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !verdict.ready |-> !(advance && last_s1))
		else $error("verdict overwritten while stalled");

endmodule
